// ----- rtl/core/api_frame_receiver_assert.svh -----
// assertion macros for the api frame receiver
// used by api_frame_receiver.sv, expects clk and rst in scope
`ifndef API_FRAME_RECEIVER_ASSERT_SVH
`define API_FRAME_RECEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define AFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AFR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AFR_ASSERT(lbl, prop, msg)
`define AFR_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/afr_pkg.sv -----
// shared types and constants for the api frame receiver
// no dependencies
package afr_pkg;

  localparam logic [7:0]  DELIM            = 8'h7e;
  localparam logic [7:0]  CSUM_BASE        = 8'hff;
  localparam logic [7:0]  FT_ADDR_DATA     = 8'h85;
  localparam logic [7:0]  FT_CMD_RESP      = 8'h88;
  localparam logic [7:0]  FT_RX_PACKET     = 8'h90;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd1020;

  localparam logic [2:0] ROLE_SHORT_ADDR = 3'd0;
  localparam logic [2:0] ROLE_LONG_ADDR  = 3'd1;
  localparam logic [2:0] ROLE_SEQUENCE   = 3'd2;
  localparam logic [2:0] ROLE_COMMAND    = 3'd3;
  localparam logic [2:0] ROLE_OPTIONS    = 3'd4;
  localparam logic [2:0] ROLE_PAYLOAD    = 3'd5;
  localparam logic [2:0] ROLE_END        = 3'd6;

  localparam logic [1:0] STATUS_GOOD     = 2'd0;
  localparam logic [1:0] STATUS_BAD_CSUM = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  typedef enum logic [5:0] {
    PH_HUNT   = 6'b000001,
    PH_LEN_HI = 6'b000010,
    PH_LEN_LO = 6'b000100,
    PH_TYPE   = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_CSUM   = 6'b100000
  } phase_t;

endpackage

// ----- rtl/core/api_frame_receiver.sv -----
// api frame receiver: byte parser with one output register
// depends on afr_pkg and api_frame_receiver_assert.svh

// Takes one received byte per cycle and emits at most one result per byte,
// in the cycle after the transfer, through a single output register. A new byte
// is taken every cycle as long as the output register is empty or being taken
// in the same cycle, so the sustained rate is one byte per clock; in_stall is
// raised only while a result waits under out_stall. Each frame ends in one
// item with last set, carrying good, bad checksum or too long. max_length may
// be rewritten only while no frame is in progress.
`include "api_frame_receiver_assert.svh"

module api_frame_receiver
  import afr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  role,
  output logic [7:0]  frame_type,
  output logic [15:0] position,
  output logic [7:0]  value,
  output logic [1:0]  status,
  output logic        last
);

  phase_t      phase, phase_next;
  logic [15:0] max_length;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] byte_count, byte_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  current_type, current_type_next;

  logic        accept;
  logic        emit;
  logic [2:0]  emit_role;
  logic [15:0] emit_pos;
  logic [7:0]  emit_value;
  logic [1:0]  emit_status;
  logic        emit_last;

  logic        lbl_hit;
  logic [2:0]  lbl_role;
  logic [15:0] lbl_pos;
  logic [15:0] len_full;
  logic [15:0] count_inc;
  logic [7:0]  csum_expect;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign len_full    = {frame_length[15:8], rx_byte};
  assign count_inc   = byte_count + 16'd1;
  assign csum_expect = CSUM_BASE - running_sum;

  // role of a data byte at index byte_count
  always_comb begin
    lbl_hit  = 1'b0;
    lbl_role = ROLE_PAYLOAD;
    lbl_pos  = '0;
    if (current_type inside {FT_ADDR_DATA, FT_RX_PACKET}) begin
      lbl_hit = 1'b1;
      if (byte_count <= 16'd2) begin
        lbl_role = ROLE_SHORT_ADDR;
        lbl_pos  = byte_count - 16'd1;
      end else if (byte_count <= 16'd10) begin
        lbl_role = ROLE_LONG_ADDR;
        lbl_pos  = byte_count - 16'd3;
      end else if (current_type == FT_RX_PACKET) begin
        if (byte_count == 16'd11) begin
          lbl_role = ROLE_OPTIONS;
          lbl_pos  = '0;
        end else begin
          lbl_role = ROLE_PAYLOAD;
          lbl_pos  = byte_count - 16'd12;
        end
      end else begin
        lbl_role = ROLE_PAYLOAD;
        lbl_pos  = byte_count - 16'd11;
      end
    end else if (current_type == FT_CMD_RESP) begin
      lbl_hit = 1'b1;
      if (byte_count == 16'd1) begin
        lbl_role = ROLE_SEQUENCE;
        lbl_pos  = '0;
      end else if (byte_count <= 16'd3) begin
        lbl_role = ROLE_COMMAND;
        lbl_pos  = byte_count - 16'd2;
      end else if (byte_count == 16'd4) begin
        lbl_role = ROLE_OPTIONS;
        lbl_pos  = '0;
      end else begin
        lbl_role = ROLE_PAYLOAD;
        lbl_pos  = byte_count - 16'd5;
      end
    end
  end

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    byte_count_next   = byte_count;
    running_sum_next  = running_sum;
    current_type_next = current_type;
    emit        = 1'b0;
    emit_role   = ROLE_END;
    emit_pos    = '0;
    emit_value  = '0;
    emit_status = STATUS_GOOD;
    emit_last   = 1'b0;
    case (phase)
      PH_LEN_HI: begin
        frame_length_next = {rx_byte, 8'd0};
        phase_next        = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_length_next = len_full;
        byte_count_next   = '0;
        running_sum_next  = '0;
        current_type_next = '0;
        if (len_full > max_length) begin
          phase_next  = PH_HUNT;
          emit        = 1'b1;
          emit_status = STATUS_TOO_LONG;
          emit_last   = 1'b1;
        end else if (len_full == '0) begin
          phase_next = PH_CSUM;
        end else begin
          phase_next = PH_TYPE;
        end
      end
      PH_TYPE: begin
        current_type_next = rx_byte;
        running_sum_next  = rx_byte;
        byte_count_next   = 16'd1;
        phase_next        = (frame_length <= 16'd1) ? PH_CSUM : PH_DATA;
      end
      PH_DATA: begin
        running_sum_next = running_sum + rx_byte;
        byte_count_next  = count_inc;
        if (count_inc >= frame_length) begin
          phase_next = PH_CSUM;
        end
        emit       = lbl_hit;
        emit_role  = lbl_role;
        emit_pos   = lbl_pos;
        emit_value = rx_byte;
      end
      PH_CSUM: begin
        phase_next  = PH_HUNT;
        emit        = 1'b1;
        emit_status = (csum_expect == rx_byte) ? STATUS_GOOD : STATUS_BAD_CSUM;
        emit_last   = 1'b1;
      end
      default: begin
        phase_next = (rx_byte == DELIM) ? PH_LEN_HI : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      max_length   <= MAX_LENGTH_RESET;
      frame_length <= '0;
      byte_count   <= '0;
      running_sum  <= '0;
      current_type <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_length <= cfg_wdata;
      end
      if (accept) begin
        phase        <= phase_next;
        frame_length <= frame_length_next;
        byte_count   <= byte_count_next;
        running_sum  <= running_sum_next;
        current_type <= current_type_next;
        out_valid    <= emit;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded only when a result is produced
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      role       <= emit_role;
      frame_type <= current_type_next;
      position   <= emit_pos;
      value      <= emit_value;
      status     <= emit_status;
      last       <= emit_last;
    end
  end

  `AFR_ASSERT_RST(a_reset_clears_out, rst |=> !out_valid, "result valid after reset")
  `AFR_ASSERT(a_csum_ends_frame, accept && phase == PH_CSUM |=> out_valid && last, "checksum byte gave no end item")
  `AFR_ASSERT(a_end_item_shape, out_valid && last |-> role == ROLE_END && value == '0 && position == '0, "malformed end item")
  `AFR_ASSERT(a_field_item_shape, out_valid && !last |-> role != ROLE_END && status == STATUS_GOOD, "malformed field item")
  `AFR_ASSERT(a_too_long_type, out_valid && status == STATUS_TOO_LONG |-> frame_type == '0 && phase == PH_HUNT, "too long item with stale state")

endmodule

// ----- tb/sv/api_frame_receiver_tb.sv -----
// self-checking testbench for api_frame_receiver: directed table, then random frames
// depends on afr_pkg and the api_frame_receiver rtl
module api_frame_receiver_tb;
  import afr_pkg::*;

  typedef struct packed {
    logic [2:0]  role;
    logic [7:0]  ftype;
    logic [15:0] pos;
    logic [7:0]  val;
    logic [1:0]  st;
    logic        last;
  } frame_item_t;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    logic [7:0] ftype;
    logic [1:0] st;
  } table_row_t;

  localparam int CYCLE_LIMIT       = 500000;
  localparam int BYTES_PER_SETTING = 265;
  localparam int TABLE_ROWS        = 21;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  role;
  logic [7:0]  frame_type;
  logic [15:0] position;
  logic [7:0]  value;
  logic [1:0]  status;
  logic        last;

  // parser state mirrored from the byte stream
  phase_t      pr_phase = PH_HUNT;
  logic [15:0] pr_len   = '0;
  logic [15:0] pr_count = '0;
  logic [7:0]  pr_sum   = '0;
  logic [7:0]  pr_type  = '0;
  logic [15:0] pr_max   = MAX_LENGTH_RESET;

  frame_item_t pending_items[$];
  frame_item_t got_item;
  frame_item_t want_item;
  string       diffs;

  int cycles        = 0;
  int mismatches    = 0;
  int items_checked = 0;
  int bytes_sent    = 0;
  int settings_used = 1;
  int ends_good     = 0;
  int ends_bad      = 0;
  int ends_long     = 0;
  int in_gap_max    = 5;
  int stall_max     = 5;
  int stall_left    = 0;

  // too long, zero length, delimiter as data, other type with bad checksum
  table_row_t stim_table [TABLE_ROWS] = '{
    '{8'h00, 1'b0, 8'h00, STATUS_GOOD},
    '{8'hff, 1'b0, 8'h00, STATUS_GOOD},
    '{DELIM, 1'b0, 8'h00, STATUS_GOOD},
    '{8'h03, 1'b0, 8'h00, STATUS_GOOD},
    '{8'hfd, 1'b1, 8'h00, STATUS_TOO_LONG},
    '{DELIM, 1'b0, 8'h00, STATUS_GOOD},
    '{8'h00, 1'b0, 8'h00, STATUS_GOOD},
    '{8'h00, 1'b0, 8'h00, STATUS_GOOD},
    '{8'hff, 1'b1, 8'h00, STATUS_GOOD},
    '{DELIM, 1'b0, 8'h00, STATUS_GOOD},
    '{8'h00, 1'b0, 8'h00, STATUS_GOOD},
    '{8'h03, 1'b0, 8'h00, STATUS_GOOD},
    '{8'h88, 1'b0, 8'h00, STATUS_GOOD},
    '{DELIM, 1'b0, 8'h00, STATUS_GOOD},
    '{8'h12, 1'b0, 8'h00, STATUS_GOOD},
    '{8'he7, 1'b0, 8'h00, STATUS_GOOD},
    '{DELIM, 1'b0, 8'h00, STATUS_GOOD},
    '{8'h00, 1'b0, 8'h00, STATUS_GOOD},
    '{8'h01, 1'b0, 8'h00, STATUS_GOOD},
    '{8'h42, 1'b0, 8'h00, STATUS_GOOD},
    '{8'h00, 1'b1, 8'h42, STATUS_BAD_CSUM}
  };

  api_frame_receiver dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .role       (role),
    .frame_type (frame_type),
    .position   (position),
    .value      (value),
    .status     (status),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items outstanding", cycles, pending_items.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 30) $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // next state and the item, if any, caused by one accepted byte
  function automatic bit parse_byte(input logic [7:0] b, output frame_item_t item);
    logic [15:0] idx;
    parse_byte = 1'b0;
    item = '0;
    case (pr_phase)
      PH_LEN_HI: begin
        pr_len = {b, 8'h00};
        pr_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        pr_len[7:0] = b;
        pr_count = '0;
        pr_sum = '0;
        pr_type = '0;
        if (pr_len > pr_max) begin
          pr_phase = PH_HUNT;
          item = {ROLE_END, 8'h00, 16'd0, 8'd0, STATUS_TOO_LONG, 1'b1};
          parse_byte = 1'b1;
        end else begin
          pr_phase = (pr_len == 16'd0) ? PH_CSUM : PH_TYPE;
        end
      end
      PH_TYPE: begin
        pr_type = b;
        pr_sum = b;
        pr_count = 16'd1;
        pr_phase = (pr_count >= pr_len) ? PH_CSUM : PH_DATA;
      end
      PH_DATA: begin
        idx = pr_count;
        pr_sum = pr_sum + b;
        pr_count = pr_count + 16'd1;
        if (pr_count >= pr_len) pr_phase = PH_CSUM;
        item.ftype = pr_type;
        item.val = b;
        parse_byte = 1'b1;
        if (pr_type == FT_ADDR_DATA || pr_type == FT_RX_PACKET) begin
          if (idx <= 16'd2) begin
            item.role = ROLE_SHORT_ADDR;
            item.pos = idx - 16'd1;
          end else if (idx <= 16'd10) begin
            item.role = ROLE_LONG_ADDR;
            item.pos = idx - 16'd3;
          end else if (pr_type == FT_RX_PACKET && idx == 16'd11) begin
            item.role = ROLE_OPTIONS;
          end else if (pr_type == FT_RX_PACKET) begin
            item.role = ROLE_PAYLOAD;
            item.pos = idx - 16'd12;
          end else begin
            item.role = ROLE_PAYLOAD;
            item.pos = idx - 16'd11;
          end
        end else if (pr_type == FT_CMD_RESP) begin
          if (idx == 16'd1) begin
            item.role = ROLE_SEQUENCE;
          end else if (idx <= 16'd3) begin
            item.role = ROLE_COMMAND;
            item.pos = idx - 16'd2;
          end else if (idx == 16'd4) begin
            item.role = ROLE_OPTIONS;
          end else begin
            item.role = ROLE_PAYLOAD;
            item.pos = idx - 16'd5;
          end
        end else begin
          parse_byte = 1'b0;
          item = '0;
        end
      end
      PH_CSUM: begin
        pr_phase = PH_HUNT;
        item = {ROLE_END, pr_type, 16'd0, 8'd0,
                (8'(CSUM_BASE - pr_sum) == b) ? STATUS_GOOD : STATUS_BAD_CSUM, 1'b1};
        parse_byte = 1'b1;
      end
      default: pr_phase = (b == DELIM) ? PH_LEN_HI : PH_HUNT;
    endcase
  endfunction

  // output side: check every transfer, then stall the output at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got_item = {role, frame_type, position, value, status, last};
        if (pending_items.size() == 0) begin
          report_mismatch($sformatf("item with nothing expected: role %0d type %h",
                                    role, frame_type));
        end else begin
          want_item = pending_items.pop_front();
          items_checked++;
          diffs = "";
          if (got_item.role !== want_item.role) diffs = {diffs, " role"};
          if (got_item.ftype !== want_item.ftype) diffs = {diffs, " frame_type"};
          if (got_item.pos !== want_item.pos) diffs = {diffs, " position"};
          if (got_item.val !== want_item.val) diffs = {diffs, " value"};
          if (got_item.st !== want_item.st) diffs = {diffs, " status"};
          if (got_item.last !== want_item.last) diffs = {diffs, " last"};
          if (diffs != "")
            report_mismatch($sformatf(
              "item %0d wrong in%s: got %0d/%h/%0d/%h/%0d/%0b expected %0d/%h/%0d/%h/%0d/%0b",
              items_checked, diffs,
              got_item.role, got_item.ftype, got_item.pos, got_item.val, got_item.st,
              got_item.last,
              want_item.role, want_item.ftype, want_item.pos, want_item.val, want_item.st,
              want_item.last));
          if (want_item.last) begin
            if (want_item.st == STATUS_GOOD) ends_good++;
            else if (want_item.st == STATUS_BAD_CSUM) ends_bad++;
            else ends_long++;
          end
        end
        stall_left = $urandom_range(0, stall_max);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic feed(input logic [7:0] b);
    frame_item_t item;
    send_byte(b);
    if (pr_phase != PH_HUNT || b == DELIM) bytes_sent++;
    if (parse_byte(b, item)) pending_items.push_back(item);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_items.size() != 0);
  endtask

  task automatic set_max(input logic [15:0] v);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pr_max = v;
    settings_used++;
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] n;
    n = 8'($urandom_range(0, 254));
    if (n >= DELIM) n = n + 8'd1;
    return n;
  endfunction

  // one frame, a too-long header, a cut-off frame or line noise
  task automatic send_frame();
    logic [7:0]  body[$];
    logic [15:0] len;
    logic [7:0]  ty;
    logic [7:0]  sum;
    logic [7:0]  d;
    int          pick;
    int          cap;
    pick = $urandom_range(0, 99);
    in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
    stall_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
    if (pick < 8) begin
      repeat ($urandom_range(1, 4)) body.push_back(noise_byte());
    end else if (pick < 16 && pr_max < 16'hffff) begin
      len = 16'($urandom_range(int'(pr_max) + 1, 65535));
      body = '{DELIM, len[15:8], len[7:0]};
      repeat ($urandom_range(0, 3)) body.push_back(noise_byte());
    end else begin
      cap = (pr_max < 30) ? int'(pr_max) : 30;
      if ($urandom_range(0, 15) == 0) cap = (pr_max < 300) ? int'(pr_max) : 300;
      len = 16'($urandom_range(0, cap));
      case ($urandom_range(0, 4))
        0: ty = FT_ADDR_DATA;
        1: ty = FT_CMD_RESP;
        2: ty = FT_RX_PACKET;
        default: ty = 8'($urandom);
      endcase
      body = '{DELIM, len[15:8], len[7:0]};
      sum = '0;
      for (int i = 0; i < int'(len); i++) begin
        d = (i == 0) ? ty : 8'($urandom);
        sum = sum + d;
        body.push_back(d);
      end
      if ($urandom_range(0, 7) == 0)
        body.push_back(8'(CSUM_BASE - sum + 8'($urandom_range(1, 255))));
      else
        body.push_back(8'(CSUM_BASE - sum));
      if (pick < 22 && pr_max <= 16'd2000)
        body = body[0 : $urandom_range(0, body.size() - 2)];
    end
    if ($urandom_range(0, 39) == 0) wait_drained();
    foreach (body[i]) feed(body[i]);
  endtask

  task automatic run_setting(input int n_bytes);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) send_frame();
    // finish any frame left open so the next register write lands between frames
    while (pr_phase != PH_HUNT) feed(8'($urandom));
  endtask

  initial begin
    frame_item_t item;
    bit          got_one;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    rx_byte <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      send_byte(stim_table[i].b);
      if (stim_table[i].b == DELIM || pr_phase != PH_HUNT) bytes_sent++;
      got_one = parse_byte(stim_table[i].b, item);
      if (stim_table[i].typed)
        pending_items.push_back({ROLE_END, stim_table[i].ftype, 16'd0, 8'd0,
                                 stim_table[i].st, 1'b1});
      else if (got_one)
        pending_items.push_back(item);
    end

    run_setting(BYTES_PER_SETTING);
    set_max(16'd1);
    run_setting(BYTES_PER_SETTING);
    set_max(16'hffff);
    run_setting(BYTES_PER_SETTING);
    set_max(16'd20);
    run_setting(BYTES_PER_SETTING);
    set_max(16'($urandom_range(21, 2000)));
    run_setting(BYTES_PER_SETTING);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("%0d frame bytes over %0d max_length settings, %0d items checked",
             bytes_sent, settings_used, items_checked);
    $display("frame ends seen: %0d good, %0d bad checksum, %0d too long",
             ends_good, ends_bad, ends_long);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
